/* sv/obuw_pkg.sv */
package obuw_pkg;

  localparam int unsigned IDX_W      = 16;
  localparam int unsigned OFF_W      = 32;
  localparam int unsigned PAY_W      = 56;
  localparam int unsigned LEB_CNT_W  = 4;
  localparam int unsigned HF_W       = 10;
  localparam int unsigned HL_W       = 4;
  localparam int unsigned LEB_BITS   = 7;
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int unsigned OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_HDR,
    PH_EXT,
    PH_LEB,
    PH_PAY,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    ST_OBU_OK,
    ST_PARSE_ERR,
    ST_TRUNC,
    ST_DONE
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   obu_index;
    logic [OFF_W-1:0]   obu_offset;
    logic [3:0]         obu_kind;
    logic               extension_present;
    logic [2:0]         temporal_layer;
    logic [1:0]         spatial_layer;
    logic [HL_W-1:0]    header_length;
    logic [PAY_W-1:0]   payload_length;
    logic [OFF_W-1:0]   have_bytes;
    logic               last_of_run;
  } result_t;

  // header byte + optional extension byte + size bytes
  function automatic logic [HL_W-1:0] hdr_len(input logic ext,
                                              input logic [LEB_CNT_W-1:0] cnt);
    hdr_len = 4'd1 + {3'b000, ext} + cnt;
  endfunction

endpackage

/* sv/obuw_outq.sv */
module obuw_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_n,
  input  obuw_pkg::result_t wr0,
  input  obuw_pkg::result_t wr1,
  input  logic              out_stall,
  output obuw_pkg::result_t head,
  output logic              head_valid,
  output logic              room
);
  import obuw_pkg::*;

  result_t              mem_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]   wp_r, wp_nxt;
  logic [OUTQ_AW-1:0]   rp_r, rp_nxt;
  logic [OUTQ_CW-1:0]   cnt_r, cnt_nxt;
  logic [OUTQ_AW-1:0]   wp_plus1;
  logic                 pop;

  assign head_valid = (cnt_r != '0);
  assign pop        = head_valid && !out_stall;
  assign head       = mem_r[rp_r];
  // one byte can produce two results, so keep two slots free
  assign room       = (cnt_r <= OUTQ_CW'(OUTQ_DEPTH - 2));
  assign wp_plus1   = wp_r + OUTQ_AW'(1);

  always_comb begin
    wp_nxt  = wp_r + OUTQ_AW'(push_n);
    rp_nxt  = rp_r + OUTQ_AW'(pop);
    cnt_nxt = cnt_r + OUTQ_CW'(push_n) - OUTQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wp_r] <= wr0;
    end
    if (push_n == 2'd2) begin
      mem_r[wp_plus1] <= wr1;
    end
  end

endmodule

/* sv/av1_obu_header_walker_top.sv */
// AV1 OBU header walker. Takes one sample byte per transfer, in_sample_end on
// the last byte of each sample, and walks header byte, optional extension byte
// and LEB128 size (up to MAX_LEB_BYTES bytes) of each OBU, skipping payloads.
// A byte is taken every cycle while in_stall is low: the parse state updates in
// the cycle of the transfer and its results go into a four-entry result queue.
// A byte gives at most two results (an OBU report or error, then the sample
// summary); these leave in order, one per out_ transfer. in_stall rises when
// the queue has fewer than two free entries, so sustained rate is one byte per
// cycle as long as the result side drains about one result per byte.
module av1_obu_header_walker_top #(
  parameter int unsigned MAX_LEB_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_sample_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [obuw_pkg::IDX_W-1:0]    out_obu_index,
  output logic [obuw_pkg::OFF_W-1:0]    out_obu_offset,
  output logic [3:0]                    out_obu_kind,
  output logic                          out_extension_present,
  output logic [2:0]                    out_temporal_layer,
  output logic [1:0]                    out_spatial_layer,
  output logic [obuw_pkg::HL_W-1:0]     out_header_length,
  output logic [obuw_pkg::PAY_W-1:0]    out_payload_length,
  output logic [obuw_pkg::OFF_W-1:0]    out_have_bytes,
  output logic                          out_last_of_run
);
  import obuw_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [OFF_W-1:0]     sample_offset_r, sample_offset_nxt;
  logic [OFF_W-1:0]     obu_start_r, obu_start_nxt;
  logic [IDX_W-1:0]     obu_count_r, obu_count_nxt;
  logic [HF_W-1:0]      hf_r, hf_nxt;
  logic [PAY_W-1:0]     acc_r, acc_nxt;
  logic [LEB_CNT_W-1:0] leb_cnt_r, leb_cnt_nxt;
  logic [PAY_W-1:0]     rem_r, rem_nxt;

  logic                 in_xfer;
  logic                 room;
  logic [OFF_W-1:0]     len;
  logic [OFF_W-1:0]     left;
  logic [5:0]           shamt;
  logic [PAY_W-1:0]     leb_sum;
  logic                 err, fin;
  logic [HL_W-1:0]      hl;
  logic                 v_mid, v_tail;
  result_t              rec_mid, rec_done, wr0, wr1, head;
  logic [1:0]           push_n;
  logic                 head_valid;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = !room;
  assign len      = sample_offset_r + OFF_W'(1);
  assign shamt    = 6'(LEB_BITS) * {3'b000, leb_cnt_r[2:0]};
  assign leb_sum  = acc_r | ({{(PAY_W-LEB_BITS){1'b0}}, in_data_byte[6:0]} << shamt);

  always_comb begin
    phase_nxt         = phase_r;
    sample_offset_nxt = len;
    obu_start_nxt     = obu_start_r;
    obu_count_nxt     = obu_count_r;
    hf_nxt            = hf_r;
    acc_nxt           = acc_r;
    leb_cnt_nxt       = leb_cnt_r;
    rem_nxt           = rem_r;
    err               = 1'b0;
    fin               = 1'b0;
    hl                = '0;

    case (phase_r)
      PH_HDR: begin
        obu_start_nxt = sample_offset_r;
        hf_nxt        = {5'b00000, in_data_byte[2], in_data_byte[6:3]};
        acc_nxt       = '0;
        leb_cnt_nxt   = '0;
        rem_nxt       = '0;
        if (in_data_byte[7] || !in_data_byte[1]) begin
          err = 1'b1;
          hl  = HL_W'(1);
        end else begin
          phase_nxt = in_data_byte[2] ? PH_EXT : PH_LEB;
        end
      end
      PH_EXT: begin
        hf_nxt    = hf_r | {in_data_byte[4:3], in_data_byte[7:5], 5'b00000};
        phase_nxt = PH_LEB;
      end
      PH_LEB: begin
        acc_nxt     = leb_sum;
        leb_cnt_nxt = leb_cnt_r + LEB_CNT_W'(1);
        if (!in_data_byte[7]) begin
          if (leb_sum == '0) begin
            fin = 1'b1;
          end else begin
            rem_nxt   = leb_sum;
            phase_nxt = PH_PAY;
          end
        end else if (leb_cnt_nxt >= LEB_CNT_W'(MAX_LEB_BYTES)) begin
          err = 1'b1;
        end
        hl = hdr_len(hf_r[4], leb_cnt_nxt);
      end
      PH_PAY: begin
        rem_nxt = rem_r - PAY_W'(1);
        if (rem_nxt == '0) begin
          fin = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // OBU report or parse error raised by this byte
    rec_mid.status            = err ? ST_PARSE_ERR : ST_OBU_OK;
    rec_mid.obu_index         = obu_count_r;
    rec_mid.obu_offset        = obu_start_nxt;
    rec_mid.obu_kind          = hf_nxt[3:0];
    rec_mid.extension_present = hf_nxt[4];
    rec_mid.temporal_layer    = hf_nxt[7:5];
    rec_mid.spatial_layer     = hf_nxt[9:8];
    rec_mid.header_length     = err ? hl : hdr_len(hf_nxt[4], leb_cnt_nxt);
    rec_mid.payload_length    = err ? '0 : acc_nxt;
    rec_mid.have_bytes        = '0;
    rec_mid.last_of_run       = 1'b0;

    if (err) begin
      phase_nxt = PH_SKIP;
    end else if (fin) begin
      obu_count_nxt = obu_count_r + IDX_W'(1);
      obu_start_nxt = len;
      phase_nxt     = PH_HDR;
    end

    left   = len - obu_start_nxt;
    v_tail = in_sample_end &&
             (phase_nxt == PH_EXT || phase_nxt == PH_LEB || phase_nxt == PH_PAY);

    // sample ended inside a header or payload
    if (!(err || fin)) begin
      rec_mid.status         = (phase_nxt == PH_PAY) ? ST_TRUNC : ST_PARSE_ERR;
      rec_mid.header_length  = hdr_len(hf_nxt[4], leb_cnt_nxt);
      rec_mid.payload_length = (phase_nxt == PH_PAY) ? acc_nxt : '0;
      rec_mid.have_bytes     = (phase_nxt == PH_PAY) ? left : '0;
    end
    v_mid = err || fin || v_tail;

    rec_done.status            = ST_DONE;
    rec_done.obu_index         = obu_count_nxt;
    rec_done.obu_offset        = obu_start_nxt;
    rec_done.obu_kind          = '0;
    rec_done.extension_present = 1'b0;
    rec_done.temporal_layer    = '0;
    rec_done.spatial_layer     = '0;
    rec_done.header_length     = '0;
    rec_done.payload_length    = '0;
    rec_done.have_bytes        = left;
    rec_done.last_of_run       = 1'b1;

    if (in_sample_end) begin
      phase_nxt         = PH_HDR;
      sample_offset_nxt = '0;
      obu_start_nxt     = '0;
      obu_count_nxt     = '0;
      hf_nxt            = '0;
      acc_nxt           = '0;
      leb_cnt_nxt       = '0;
      rem_nxt           = '0;
    end
  end

  always_comb begin
    wr0             = v_mid ? rec_mid : rec_done;
    wr0.last_of_run = !(v_mid && in_sample_end);
    wr1             = rec_done;
    push_n          = in_xfer ? ({1'b0, v_mid} + {1'b0, in_sample_end}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HDR;
      sample_offset_r <= '0;
      obu_start_r     <= '0;
      obu_count_r     <= '0;
      hf_r            <= '0;
      acc_r           <= '0;
      leb_cnt_r       <= '0;
      rem_r           <= '0;
    end else if (in_xfer) begin
      phase_r         <= phase_nxt;
      sample_offset_r <= sample_offset_nxt;
      obu_start_r     <= obu_start_nxt;
      obu_count_r     <= obu_count_nxt;
      hf_r            <= hf_nxt;
      acc_r           <= acc_nxt;
      leb_cnt_r       <= leb_cnt_nxt;
      rem_r           <= rem_nxt;
    end
  end

  obuw_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (push_n),
    .wr0        (wr0),
    .wr1        (wr1),
    .out_stall  (out_stall),
    .head       (head),
    .head_valid (head_valid),
    .room       (room)
  );

  assign out_valid             = head_valid;
  assign out_status            = head.status;
  assign out_obu_index         = head.obu_index;
  assign out_obu_offset        = head.obu_offset;
  assign out_obu_kind          = head.obu_kind;
  assign out_extension_present = head.extension_present;
  assign out_temporal_layer    = head.temporal_layer;
  assign out_spatial_layer     = head.spatial_layer;
  assign out_header_length     = head.header_length;
  assign out_payload_length    = head.payload_length;
  assign out_have_bytes        = head.have_bytes;
  assign out_last_of_run       = head.last_of_run;

  a_sample_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_sample_end |=> sample_offset_r == '0 && phase_r == PH_HDR
                                 && obu_count_r == '0)
    else $error("per-sample state not cleared at sample end");

  a_offset_advances: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !in_sample_end |=> sample_offset_r == $past(sample_offset_r) + OFF_W'(1))
    else $error("sample offset did not advance by one");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAY |-> rem_r != '0)
    else $error("payload phase with nothing left to skip");

  a_leb_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LEB |-> leb_cnt_r < LEB_CNT_W'(MAX_LEB_BYTES))
    else $error("size field longer than allowed");

endmodule

/* test/av1_obu_header_walker_top_test.sv */
module av1_obu_header_walker_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import obuw_pkg::*;

  localparam int unsigned MAX_LEB    = 8;
  localparam int          RAND_ITEMS = 850;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_data_byte = 8'h00;
  logic                 in_sample_end = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_status;
  logic [IDX_W-1:0]     out_obu_index;
  logic [OFF_W-1:0]     out_obu_offset;
  logic [3:0]           out_obu_kind;
  logic                 out_extension_present;
  logic [2:0]           out_temporal_layer;
  logic [1:0]           out_spatial_layer;
  logic [HL_W-1:0]      out_header_length;
  logic [PAY_W-1:0]     out_payload_length;
  logic [OFF_W-1:0]     out_have_bytes;
  logic                 out_last_of_run;

  av1_obu_header_walker_top #(
    .MAX_LEB_BYTES(MAX_LEB)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .in_sample_end        (in_sample_end),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_obu_index        (out_obu_index),
    .out_obu_offset       (out_obu_offset),
    .out_obu_kind         (out_obu_kind),
    .out_extension_present(out_extension_present),
    .out_temporal_layer   (out_temporal_layer),
    .out_spatial_layer    (out_spatial_layer),
    .out_header_length    (out_header_length),
    .out_payload_length   (out_payload_length),
    .out_have_bytes       (out_have_bytes),
    .out_last_of_run      (out_last_of_run)
  );

  always #4 clk = ~clk;

  typedef struct {
    logic [7:0] data;
    logic       eos;
    int         n_typed;
    result_t    r0;
    result_t    r1;
  } dir_row_t;

  dir_row_t    dir_rows[$];
  result_t     pending_results[$];
  result_t     byte_results[$];
  logic [7:0]  sample_bytes[$];
  int          err_count = 0;
  int          in_idle_pct = 11;
  int          out_stall_pct = 57;
  bit          stress_phase = 1'b0;
  logic        rx_hold = 1'b0;

  // walker state
  phase_t         walk_phase;
  logic [31:0]    walk_offset;
  logic [31:0]    walk_start;
  logic [15:0]    walk_count;
  logic [3:0]     hf_kind;
  logic           hf_ext;
  logic [2:0]     hf_tl;
  logic [1:0]     hf_sl;
  logic [55:0]    leb_acc;
  logic [3:0]     leb_cnt;
  logic [55:0]    pay_left;

  function automatic result_t mk(status_t st, logic [15:0] idx, logic [31:0] off,
                                 logic [3:0] ty, logic ext, logic [2:0] tl,
                                 logic [1:0] sl, logic [3:0] hl, logic [55:0] pl,
                                 logic [31:0] hb, logic last);
    result_t r;
    r.status            = st;
    r.obu_index         = idx;
    r.obu_offset        = off;
    r.obu_kind          = ty;
    r.extension_present = ext;
    r.temporal_layer    = tl;
    r.spatial_layer     = sl;
    r.header_length     = hl;
    r.payload_length    = pl;
    r.have_bytes        = hb;
    r.last_of_run       = last;
    return r;
  endfunction

  function automatic logic [3:0] hdr_bytes();
    return 4'd1 + {3'b000, hf_ext} + leb_cnt;
  endfunction

  task automatic clear_walk();
    walk_phase  = PH_HDR;
    walk_offset = '0;
    walk_start  = '0;
    walk_count  = '0;
    hf_kind     = '0;
    hf_ext      = 1'b0;
    hf_tl       = '0;
    hf_sl       = '0;
    leb_acc     = '0;
    leb_cnt     = '0;
    pay_left    = '0;
  endtask

  // One accepted byte: advance the walker, leave its results in byte_results.
  task automatic walk_byte(input logic [7:0] d, input logic e);
    logic [31:0] pos;
    logic [31:0] len;
    logic [31:0] left;
    logic [3:0]  hl;
    logic        err;
    logic        fin;
    logic [63:0] part;
    byte_results.delete();
    pos = walk_offset;
    len = pos + 32'd1;
    hl  = '0;
    err = 1'b0;
    fin = 1'b0;
    case (walk_phase)
      PH_HDR: begin
        walk_start = pos;
        hf_kind    = d[6:3];
        hf_ext     = d[2];
        hf_tl      = '0;
        hf_sl      = '0;
        leb_acc    = '0;
        leb_cnt    = '0;
        pay_left   = '0;
        if (d[7] || !d[1]) begin
          err = 1'b1;
          hl  = 4'd1;
        end else begin
          walk_phase = d[2] ? PH_EXT : PH_LEB;
        end
      end
      PH_EXT: begin
        hf_tl      = d[7:5];
        hf_sl      = d[4:3];
        walk_phase = PH_LEB;
      end
      PH_LEB: begin
        part    = {57'd0, d[6:0]} << (7 * leb_cnt[2:0]);
        leb_acc = leb_acc | part[55:0];
        leb_cnt = leb_cnt + 4'd1;
        if (!d[7]) begin
          if (leb_acc == '0) begin
            fin = 1'b1;
          end else begin
            pay_left   = leb_acc;
            walk_phase = PH_PAY;
          end
        end else if (leb_cnt >= 4'(MAX_LEB)) begin
          err = 1'b1;
        end
        hl = hdr_bytes();
      end
      PH_PAY: begin
        pay_left = pay_left - 56'd1;
        if (pay_left == '0) fin = 1'b1;
      end
      default: ;
    endcase

    if (err) begin
      byte_results.insert(byte_results.size(),
                          mk(ST_PARSE_ERR, walk_count, walk_start, hf_kind, hf_ext,
                             hf_tl, hf_sl, hl, '0, '0, 1'b0));
      walk_phase = PH_SKIP;
    end else if (fin) begin
      byte_results.insert(byte_results.size(),
                          mk(ST_OBU_OK, walk_count, walk_start, hf_kind, hf_ext,
                             hf_tl, hf_sl, hdr_bytes(), leb_acc, '0, 1'b0));
      walk_count = walk_count + 16'd1;
      walk_start = len;
      walk_phase = PH_HDR;
    end

    if (e) begin
      left = len - walk_start;
      if (walk_phase == PH_EXT || walk_phase == PH_LEB) begin
        byte_results.insert(byte_results.size(),
                            mk(ST_PARSE_ERR, walk_count, walk_start, hf_kind, hf_ext,
                               hf_tl, hf_sl, hdr_bytes(), '0, '0, 1'b0));
      end else if (walk_phase == PH_PAY) begin
        byte_results.insert(byte_results.size(),
                            mk(ST_TRUNC, walk_count, walk_start, hf_kind, hf_ext,
                               hf_tl, hf_sl, hdr_bytes(), leb_acc, left, 1'b0));
      end
      byte_results.insert(byte_results.size(),
                          mk(ST_DONE, walk_count, walk_start, '0, 1'b0, '0, '0,
                             '0, '0, left, 1'b0));
      clear_walk();
    end else begin
      walk_offset = len;
    end

    if (byte_results.size() > 0)
      byte_results[byte_results.size() - 1].last_of_run = 1'b1;
  endtask

  task automatic add_row(input logic [7:0] d, input logic e, input int n,
                         input result_t r0, input result_t r1);
    dir_row_t row;
    row.data    = d;
    row.eos     = e;
    row.n_typed = n;
    row.r0      = r0;
    row.r1      = r1;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Offer one byte; returns at the edge of its transfer.
  task automatic send_byte(input logic [7:0] d, input logic e, input int n_typed,
                           input result_t r0, input result_t r1);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= d;
    in_sample_end <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    walk_byte(d, e);
    if (n_typed > 0) begin
      pending_results.insert(pending_results.size(), r0);
      if (n_typed > 1) pending_results.insert(pending_results.size(), r1);
    end else begin
      foreach (byte_results[i])
        pending_results.insert(pending_results.size(), byte_results[i]);
    end
  endtask

  task automatic push_leb(input int unsigned v, input int unsigned pad);
    logic [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0 || pad != 0) b[7] = 1'b1;
      sample_bytes.insert(sample_bytes.size(), b);
    end while (v != 0);
    while (pad > 0) begin
      pad = pad - 1;
      sample_bytes.insert(sample_bytes.size(), (pad != 0) ? 8'h80 : 8'h00);
    end
  endtask

  task automatic push_header();
    logic [7:0] hdr;
    hdr    = 8'($urandom);
    hdr[7] = 1'b0;
    hdr[1] = 1'b1;
    sample_bytes.insert(sample_bytes.size(), hdr);
    if (hdr[2]) sample_bytes.insert(sample_bytes.size(), 8'($urandom));
  endtask

  task automatic build_sample();
    int          kind;
    int unsigned plen;
    int          cut;
    logic [7:0]  hdr;
    sample_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 70) begin
      // well-formed OBUs, sometimes cut short anywhere
      repeat ($urandom_range(4, 1)) begin
        push_header();
        plen = ($urandom_range(11) == 0) ? $urandom_range(200) : $urandom_range(10);
        push_leb(plen, ($urandom_range(3) == 0) ? $urandom_range(MAX_LEB - 2) : 0);
        repeat (plen) sample_bytes.insert(sample_bytes.size(), 8'($urandom));
      end
      if ($urandom_range(4) == 0) begin
        cut = $urandom_range(sample_bytes.size(), 1);
        while (sample_bytes.size() > cut) void'(sample_bytes.pop_back());
      end
    end else if (kind < 80) begin
      // size field at its longest: unterminated or huge payload
      push_header();
      if ($urandom_range(1)) begin
        repeat (MAX_LEB) sample_bytes.insert(sample_bytes.size(), 8'h80 | 8'($urandom));
      end else begin
        repeat (MAX_LEB - 1)
          sample_bytes.insert(sample_bytes.size(), 8'h80 | 8'($urandom));
        sample_bytes.insert(sample_bytes.size(), 8'h7F & 8'($urandom));
      end
      repeat ($urandom_range(3)) sample_bytes.insert(sample_bytes.size(), 8'($urandom));
    end else if (kind < 90) begin
      hdr = 8'($urandom);
      if ($urandom_range(1)) hdr[7] = 1'b1;
      else hdr[1] = 1'b0;
      sample_bytes.insert(sample_bytes.size(), hdr);
      repeat ($urandom_range(5)) sample_bytes.insert(sample_bytes.size(), 8'($urandom));
    end else begin
      repeat ($urandom_range(8, 1)) sample_bytes.insert(sample_bytes.size(), 8'($urandom));
    end
  endtask

  task automatic cmp_field(input string name, input logic [63:0] e, input logic [63:0] a);
    if (a !== e) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, e, a);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with nothing expected, status %0d offset 0x%0h",
                 $time, out_status, out_obu_offset);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        cmp_field("status", 64'(want.status), 64'(out_status));
        cmp_field("obu_index", 64'(want.obu_index), 64'(out_obu_index));
        cmp_field("obu_offset", 64'(want.obu_offset), 64'(out_obu_offset));
        cmp_field("obu_kind", 64'(want.obu_kind), 64'(out_obu_kind));
        cmp_field("extension_present", 64'(want.extension_present),
                  64'(out_extension_present));
        cmp_field("temporal_layer", 64'(want.temporal_layer), 64'(out_temporal_layer));
        cmp_field("spatial_layer", 64'(want.spatial_layer), 64'(out_spatial_layer));
        cmp_field("header_length", 64'(want.header_length), 64'(out_header_length));
        cmp_field("payload_length", 64'(want.payload_length), 64'(out_payload_length));
        cmp_field("have_bytes", 64'(want.have_bytes), 64'(out_have_bytes));
        cmp_field("last_of_run", 64'(want.last_of_run), 64'(out_last_of_run));
      end
    end
    out_stall <= rx_hold || ($urandom_range(99) < out_stall_pct);
  end

  // long receiver hold-off so the result queue fills and in_stall rises
  initial begin : hold_off
    wait (stress_phase);
    repeat (30) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (80) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : run_limit
    #5_000_000;
    $display("av1_obu_header_walker_top_test: done, errors");
    $finish;
  end

  initial begin : stim
    int sent;
    int n;
    clear_walk();
    // forbidden bit, right after reset
    add_row(8'h80, 1'b1, 2,
            mk(ST_PARSE_ERR, '0, '0, 4'h0, 1'b0, '0, '0, 4'd1, '0, '0, 1'b0),
            mk(ST_DONE, '0, '0, 4'h0, 1'b0, '0, '0, 4'd0, '0, 32'd1, 1'b1));
    // size flag clear
    add_row(8'h7D, 1'b1, 2,
            mk(ST_PARSE_ERR, '0, '0, 4'hF, 1'b1, '0, '0, 4'd1, '0, '0, 1'b0),
            mk(ST_DONE, '0, '0, 4'h0, 1'b0, '0, '0, 4'd0, '0, 32'd1, 1'b1));
    // extension with top layer ids, zero payload, then a two-byte payload
    add_row(8'h36, 1'b0, 0, '0, '0);
    add_row(8'hFF, 1'b0, 0, '0, '0);
    add_row(8'h00, 1'b0, 1,
            mk(ST_OBU_OK, '0, '0, 4'h6, 1'b1, 3'd7, 2'd3, 4'd3, '0, '0, 1'b1), '0);
    add_row(8'h12, 1'b0, 0, '0, '0);
    add_row(8'h02, 1'b0, 0, '0, '0);
    add_row(8'hAA, 1'b0, 0, '0, '0);
    add_row(8'h55, 1'b1, 0, '0, '0);
    // size field never terminates, then the rest is skipped
    add_row(8'h0A, 1'b0, 0, '0, '0);
    repeat (MAX_LEB - 1) add_row(8'hFF, 1'b0, 0, '0, '0);
    add_row(8'hFF, 1'b0, 1,
            mk(ST_PARSE_ERR, '0, '0, 4'h1, 1'b0, '0, '0, 4'd9, '0, '0, 1'b1), '0);
    add_row(8'h55, 1'b1, 1,
            mk(ST_DONE, '0, '0, 4'h0, 1'b0, '0, '0, 4'd0, '0, 32'd10, 1'b1), '0);
    // payload cut short
    add_row(8'h12, 1'b0, 0, '0, '0);
    add_row(8'h05, 1'b0, 0, '0, '0);
    add_row(8'h00, 1'b1, 0, '0, '0);
    // sample ends inside the header
    add_row(8'h16, 1'b1, 0, '0, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_byte(dir_rows[i].data, dir_rows[i].eos, dir_rows[i].n_typed,
                dir_rows[i].r0, dir_rows[i].r1);

    sent = 0;
    while (sent < RAND_ITEMS) begin
      if (sent >= 2 * RAND_ITEMS / 3) begin
        in_idle_pct   = 0;
        out_stall_pct = 0;
        stress_phase  = 1'b1;
      end else if (sent >= RAND_ITEMS / 3) begin
        in_idle_pct   = 57;
        out_stall_pct = 11;
      end
      build_sample();
      n = sample_bytes.size();
      foreach (sample_bytes[i])
        send_byte(sample_bytes[i], (i == n - 1), 0, '0, '0);
      sent += n;
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("av1_obu_header_walker_top_test: done, clean");
    end else begin
      $display("av1_obu_header_walker_top_test: done, errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/obuw_pkg.sv
sv/obuw_outq.sv
sv/av1_obu_header_walker_top.sv
test/av1_obu_header_walker_top_test.sv
